// File: design/pimr_pkg.sv
// Package for the posted-interrupt merge router: word types, codes and constants.
// Used by the top level, the posted/request word RAM and the port checker.
`default_nettype none

package pimr_pkg;

    localparam int WORD_BITS = 32;

    // Input word: one post or one notification.
    typedef struct packed {
        logic       command;
        logic [7:0] vector;
        logic [7:0] priority_level;
    } pimr_in_t;

    // Result word: one per input word.
    typedef struct packed {
        logic [1:0] route;
        logic [7:0] requested_vector_out;
        logic       eoi_sent;
    } pimr_out_t;

    localparam logic CMD_POST   = 1'b0;
    localparam logic CMD_NOTIFY = 1'b1;

    localparam logic [1:0] ROUTE_HOST_EXIT   = 2'd0;
    localparam logic [1:0] ROUTE_RESUME      = 2'd1;
    localparam logic [1:0] ROUTE_EXIT_L1     = 2'd2;
    localparam logic [1:0] ROUTE_POST_ACCEPT = 2'd3;

    localparam logic [7:0] CFG_POSTING_ENABLE = 8'd0;
    localparam logic [7:0] CFG_NOTIFY_VECTOR  = 8'd1;

    localparam logic [7:0] CLASS_MASK       = 8'hF0;
    localparam logic [7:0] LOW_VECTOR_LIMIT = 8'd31;

endpackage : pimr_pkg

`default_nettype wire

// File: design/posted_interrupt_merge_router.sv
// Flow: a post passes through the write state before its result is emitted; a host
// exit goes straight to emit; a processed notification walks the posted words, then
// decides, skipping the walk when nothing is posted. Throughput: one word at a time;
// the walk reads one posted word per cycle from the posted RAM.
// Reset: synchronous active-low aresetn clears flags, config, requested vector and
// the RAM valid bits at once; there is no clearing pass.
`default_nettype none

module posted_interrupt_merge_router
    import pimr_pkg::*;
#(
    parameter int POSTED_WORDS = 8
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire pimr_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pimr_out_t      m_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = (POSTED_WORDS > 1) ? $clog2(POSTED_WORDS) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(POSTED_WORDS - 1);
    localparam logic [3:0]    WORDS4   = 4'(POSTED_WORDS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POST_WR,
        ST_WALK,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t    state_reg;
    logic      m_valid_reg;
    pimr_out_t m_data_reg;
    pimr_out_t res_reg;
    logic      posting_enable_reg;
    logic [7:0] notify_vector_reg;
    logic      notify_pending_reg;
    logic [7:0] req_vec_reg;
    logic [7:0] vec_reg;
    logic [7:0] prio_reg;
    logic      post_hit_reg;
    logic [AW-1:0] idx_reg;
    logic [7:0] top_reg;

    logic s_acc;
    logic out_free;
    logic post_in_range;
    logic notify_hit;
    logic walk_more;

    logic                 post_wr_en;
    logic [AW-1:0]        post_wr_addr;
    logic [WORD_BITS-1:0] post_wr_data;
    logic                 post_rd_en;
    logic [AW-1:0]        post_rd_addr;
    logic [WORD_BITS-1:0] post_rd_data;
    logic                 req_wr_en;
    logic [WORD_BITS-1:0] req_wr_data;
    logic                 req_rd_en;
    logic [WORD_BITS-1:0] req_rd_data;

    logic [7:0] top_eff;
    logic [7:0] req_vec_next;
    logic [1:0] route_next;

    // Highest set bit position of a word; zero for an empty word.
    function automatic logic [4:0] top_bit(input logic [WORD_BITS-1:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (w[b]) begin
                pos = 5'(b);
            end
        end
        return pos;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign post_in_range = ({1'b0, s_data.vector[7:5]} < WORDS4);
    assign notify_hit    = (s_data.command == CMD_NOTIFY) && posting_enable_reg
                           && (s_data.vector == notify_vector_reg);
    assign walk_more     = (state_reg == ST_WALK) && (idx_reg != LAST_IDX);

    // Memory port control: reads are issued in the cycle before the write-back.
    always_comb begin
        post_rd_en   = 1'b0;
        post_rd_addr = idx_reg + 1'b1;
        req_rd_en    = 1'b0;
        post_wr_en   = 1'b0;
        post_wr_addr = idx_reg;
        post_wr_data = '0;
        req_wr_en    = 1'b0;
        req_wr_data  = req_rd_data | post_rd_data;
        if (s_acc) begin
            if (s_data.command == CMD_POST) begin
                post_rd_en   = post_in_range;
                post_rd_addr = s_data.vector[5 +: AW];
            end else begin
                post_rd_en   = notify_hit && notify_pending_reg;
                req_rd_en    = notify_hit && notify_pending_reg;
                post_rd_addr = '0;
            end
        end else if (walk_more) begin
            post_rd_en = 1'b1;
            req_rd_en  = 1'b1;
        end
        if (state_reg == ST_POST_WR) begin
            post_wr_en   = post_hit_reg;
            post_wr_addr = vec_reg[5 +: AW];
            post_wr_data = post_rd_data | (WORD_BITS'(1) << vec_reg[4:0]);
        end else if (state_reg == ST_WALK) begin
            post_wr_en = 1'b1;
            req_wr_en  = 1'b1;
        end
    end

    always_comb begin
        top_eff      = (top_reg < LOW_VECTOR_LIMIT) ? 8'd0 : top_reg;
        req_vec_next = (top_eff > req_vec_reg) ? top_eff : req_vec_reg;
        route_next   = ((req_vec_next & CLASS_MASK) <= (prio_reg & CLASS_MASK))
                       ? ROUTE_RESUME : ROUTE_EXIT_L1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            m_valid_reg        <= 1'b0;
            posting_enable_reg <= 1'b0;
            notify_vector_reg  <= '0;
            notify_pending_reg <= 1'b0;
            req_vec_reg        <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_POSTING_ENABLE: posting_enable_reg <= cfg_data[0];
                    CFG_NOTIFY_VECTOR:  notify_vector_reg  <= cfg_data;
                    default: ;
                endcase
            end

            // drop the shown word once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && (state_reg != ST_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        vec_reg      <= s_data.vector;
                        prio_reg     <= s_data.priority_level;
                        post_hit_reg <= post_in_range;
                        idx_reg      <= '0;
                        top_reg      <= '0;
                        if (s_data.command == CMD_POST) begin
                            state_reg <= ST_POST_WR;
                        end else if (!notify_hit) begin
                            res_reg   <= '{ROUTE_HOST_EXIT, req_vec_reg, 1'b0};
                            state_reg <= ST_EMIT;
                        end else if (notify_pending_reg) begin
                            state_reg <= ST_WALK;
                        end else begin
                            // nothing posted since the last merge: skip the walk
                            state_reg <= ST_DECIDE;
                        end
                    end
                end
                ST_POST_WR: begin
                    notify_pending_reg <= 1'b1;
                    res_reg   <= '{ROUTE_POST_ACCEPT, req_vec_reg, 1'b0};
                    state_reg <= ST_EMIT;
                end
                ST_WALK: begin
                    if (post_rd_data != '0) begin
                        top_reg <= (8'(idx_reg) << 5) | {3'b000, top_bit(post_rd_data)};
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_DECIDE;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DECIDE: begin
                    notify_pending_reg <= 1'b0;
                    req_vec_reg <= req_vec_next;
                    res_reg     <= '{route_next, req_vec_next, 1'b1};
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT: begin
                    // hold the result until the output register is free
                    if (out_free) begin
                        m_data_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    pimr_word_ram #(
        .DEPTH (POSTED_WORDS),
        .AW    (AW)
    ) u_posted_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (post_wr_en),
        .wr_addr (post_wr_addr),
        .wr_data (post_wr_data),
        .rd_en   (post_rd_en),
        .rd_addr (post_rd_addr),
        .rd_data (post_rd_data)
    );

    pimr_word_ram #(
        .DEPTH (POSTED_WORDS),
        .AW    (AW)
    ) u_request_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (req_wr_en),
        .wr_addr (idx_reg),
        .wr_data (req_wr_data),
        .rd_en   (req_rd_en),
        .rd_addr (post_rd_addr),
        .rd_data (req_rd_data)
    );

endmodule

`default_nettype wire

// File: design/pimr_word_ram.sv
// Word RAM of 32-bit entries with one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses pimr_pkg.
`default_nettype none

module pimr_word_ram
    import pimr_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [WORD_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output logic      [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/pimr_checker.sv
// Port-level checker for the posted-interrupt merge router, bound to the top level.
// Depends on pimr_pkg for the word types and route codes.
`default_nettype none

module pimr_checker
    import pimr_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire pimr_out_t m_data
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // EOI goes with exactly the processed-notification routes.
    a_eoi_route: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.eoi_sent ==
                     (m_data.route == ROUTE_RESUME || m_data.route == ROUTE_EXIT_L1)))
        else $error("eoi flag does not match route");

    // The kept requested vector is zero or at least the low-vector limit.
    a_req_vec_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.requested_vector_out == 8'd0 ||
                     m_data.requested_vector_out >= LOW_VECTOR_LIMIT))
        else $error("requested vector below limit");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind posted_interrupt_merge_router pimr_checker u_pimr_checker (.*);

`default_nettype wire
